// ===== hw/rtl/gpio_serial_codec_control_master_top_assert.svh =====
// Assertion macros for the serial codec control master.
`ifndef GPIO_SERIAL_CODEC_CONTROL_MASTER_TOP_ASSERT_SVH
`define GPIO_SERIAL_CODEC_CONTROL_MASTER_TOP_ASSERT_SVH

// Checked only out of reset.
`define GSCM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define GSCM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/gscm_pkg.sv =====
// Shared types and constants for the serial codec control master.
package gscm_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_MASK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUT_MASK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIN_MASK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALL_SELECT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CODEC_ADDR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_XCVR_ADDR    = 3'd5;

    localparam logic [6:0] LAST_CODEC_WR = 7'd32;
    localparam logic [6:0] LAST_XCVR_WR  = 7'd48;
    localparam logic [6:0] LAST_XCVR_RD  = 7'd66;
    localparam logic [6:0] RD_PHASE_BASE = 7'd32;
    localparam logic [6:0] RD_DESELECT   = 7'd32;
    localparam logic [6:0] RD_RESELECT   = 7'd33;
    localparam logic [6:0] RD_BITS_START = 7'd50;
    localparam logic [4:0] LAST_BIT_POS  = 5'd23;

    localparam logic [7:0] CODEC_WR_FLAG  = 8'h20;
    localparam logic [7:0] CODEC_REG_MASK = 8'h1F;

    typedef enum logic [1:0] {
        OP_CODEC_WR = 2'd0,
        OP_XCVR_WR  = 2'd1,
        OP_XCVR_RD  = 2'd2,
        OP_UNUSED   = 2'd3
    } op_t;

    typedef struct packed {
        logic [7:0] clock_mask;
        logic [7:0] dout_mask;
        logic [7:0] all_select;
        logic [1:0] codec_addr;
        logic [6:0] xcvr_addr;
    } cfg_t;

    typedef struct packed {
        logic        is_tick;
        logic        op_bad;
        op_t         op;
        logic [23:0] out_bytes;
        logic [7:0]  base;
        logic [7:0]  sel;
        logic        level;
    } entry_t;

    typedef struct packed {
        logic [7:0] gpio_value;
        logic       gpio_write;
        logic       busy;
        logic       done;
        logic [7:0] read_byte;
        logic       rejected;
    } res_t;

endpackage

// ===== hw/rtl/gpio_serial_codec_control_master_top.sv =====
// Top level of the bit-banged serial codec control master.
// Every accepted item (command or tick) yields exactly one result transaction. Items are
// classified on entry, pass a four-entry queue and are executed one per cycle by the
// executor while the result output is not stalled, so the block then sustains one item per
// clock; an accepted item is written into the queue and its result is registered when the
// executor pops it. Configuration writes take effect the next cycle; the data-in line mask
// index is accepted but has no effect since the sampled level arrives with each tick.
module gpio_serial_codec_control_master_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [gscm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                       cfg_data,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic                             kind,
    input  logic [1:0]                       operation,
    input  logic [6:0]                       register_address,
    input  logic [7:0]                       write_byte,
    input  logic [7:0]                       select_mask,
    input  logic [7:0]                       gpio_now,
    input  logic                             data_in_level,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [7:0]                       gpio_value,
    output logic                             gpio_write,
    output logic                             busy_res,
    output logic                             done_res,
    output logic [7:0]                       read_byte,
    output logic                             rejected
);
    import gscm_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    logic   push, q_full, q_not_empty, pop;
    entry_t push_entry, head;
    res_t   result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_CLOCK_MASK: cfg_next.clock_mask = cfg_data;
                CFG_DOUT_MASK:  cfg_next.dout_mask  = cfg_data;
                CFG_ALL_SELECT: cfg_next.all_select = cfg_data;
                CFG_CODEC_ADDR: cfg_next.codec_addr = cfg_data[1:0];
                CFG_XCVR_ADDR:  cfg_next.xcvr_addr  = cfg_data[6:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    gscm_front u_front (
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .kind             (kind),
        .operation        (operation),
        .register_address (register_address),
        .write_byte       (write_byte),
        .select_mask      (select_mask),
        .gpio_now         (gpio_now),
        .data_in_level    (data_in_level),
        .cfg              (cfg_reg),
        .q_full           (q_full),
        .push             (push),
        .entry            (push_entry)
    );

    gscm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .not_empty  (q_not_empty),
        .head       (head)
    );

    gscm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_not_empty  (q_not_empty),
        .e            (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign gpio_value = result.gpio_value;
    assign gpio_write = result.gpio_write;
    assign busy_res   = result.busy;
    assign done_res   = result.done;
    assign read_byte  = result.read_byte;
    assign rejected   = result.rejected;

endmodule

// ===== hw/rtl/gscm_front.sv =====
// Front end: takes items and classifies them into queue entries.
module gscm_front (
    input  logic             item_valid,
    output logic             item_stall,
    input  logic             kind,
    input  logic [1:0]       operation,
    input  logic [6:0]       register_address,
    input  logic [7:0]       write_byte,
    input  logic [7:0]       select_mask,
    input  logic [7:0]       gpio_now,
    input  logic             data_in_level,
    input  gscm_pkg::cfg_t   cfg,
    input  logic             q_full,
    output logic             push,
    output gscm_pkg::entry_t entry
);
    import gscm_pkg::*;

    logic [7:0] codec_first;
    logic [7:0] xcvr_first;
    logic [7:0] reg_byte;
    op_t        op;

    assign op          = op_t'(operation);
    assign item_stall  = q_full;
    assign push        = item_valid && !q_full;
    assign codec_first = {cfg.codec_addr, 6'd0} | CODEC_WR_FLAG
                         | ({1'b0, register_address} & CODEC_REG_MASK);
    assign xcvr_first  = {cfg.xcvr_addr, 1'b0};
    assign reg_byte    = {1'b0, register_address};

    always_comb
    begin
        entry         = '0;
        entry.is_tick = kind;
        entry.op      = op;
        entry.base    = (gpio_now | cfg.all_select) & ~select_mask;
        entry.sel     = select_mask;
        entry.level   = data_in_level;
        case (op)
            OP_CODEC_WR: entry.out_bytes = {codec_first, write_byte, 8'h00};
            OP_XCVR_WR:  entry.out_bytes = {xcvr_first, reg_byte, write_byte};
            OP_XCVR_RD:  entry.out_bytes = {xcvr_first, reg_byte, xcvr_first | 8'h01};
            default:     entry.op_bad    = 1'b1;
        endcase
    end

endmodule

// ===== hw/rtl/gscm_queue.sv =====
// Short FIFO between front end and executor.
module gscm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  gscm_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output gscm_pkg::entry_t head
);
    import gscm_pkg::*;

    entry_t         mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;

    assign full      = (count_reg == (QAW+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hw/rtl/gscm_back.sv =====
// Executor: runs transactions one GPIO step per entry, registered result.
module gscm_back (
    input  logic             clk,
    input  logic             rst_n,
    input  gscm_pkg::cfg_t   cfg,
    input  logic             q_not_empty,
    input  gscm_pkg::entry_t e,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_stall,
    output gscm_pkg::res_t   result
);
    import gscm_pkg::*;

    logic [6:0]  step_reg, step_next;
    op_t         op_reg, op_next;
    logic        busy_reg, busy_next;
    logic [7:0]  shadow_reg, shadow_next;
    logic [7:0]  held_reg, held_next;
    logic [23:0] bytes_reg, bytes_next;
    logic [7:0]  incoming_reg, incoming_next;
    logic        valid_reg, valid_next;
    res_t        res_reg, res_next;
    logic [6:0]  last;

    function automatic logic [7:0] send_word(
        input logic [4:0]  k,
        input logic        high,
        input logic [23:0] bytes,
        input logic [7:0]  shadow,
        input logic [7:0]  clk_mask,
        input logic [7:0]  dout_mask
    );
        logic [4:0] pos;
        logic [7:0] v;
        pos = LAST_BIT_POS - k;
        v   = shadow & ~(clk_mask | dout_mask);
        if (bytes[pos])
            v = v | dout_mask;
        if (high)
            v = v | clk_mask;
        return v;
    endfunction

    assign pop          = q_not_empty && (!valid_reg || !result_stall);
    assign result_valid = valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        case (op_reg)
            OP_CODEC_WR: last = LAST_CODEC_WR;
            OP_XCVR_WR:  last = LAST_XCVR_WR;
            default:     last = LAST_XCVR_RD;
        endcase
    end

    always_comb
    begin
        step_next     = step_reg;
        op_next       = op_reg;
        busy_next     = busy_reg;
        shadow_next   = shadow_reg;
        held_next     = held_reg;
        bytes_next    = bytes_reg;
        incoming_next = incoming_reg;
        valid_next    = valid_reg && result_stall;
        res_next      = res_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            res_next   = '0;
            if (!e.is_tick)
            begin
                if (busy_reg || e.op_bad)
                begin
                    res_next.busy     = busy_reg;
                    res_next.rejected = 1'b1;
                end
                else
                begin
                    bytes_next          = e.out_bytes;
                    shadow_next         = e.base;
                    held_next           = e.sel;
                    op_next             = e.op;
                    busy_next           = 1'b1;
                    step_next           = '0;
                    incoming_next       = '0;
                    res_next.gpio_value = e.base;
                    res_next.gpio_write = 1'b1;
                    res_next.busy       = 1'b1;
                end
            end
            else if (busy_reg)
            begin
                if (step_reg >= last)
                begin
                    shadow_next         = shadow_reg | held_reg;
                    busy_next           = 1'b0;
                    step_next           = '0;
                    res_next.gpio_value = shadow_reg | held_reg;
                    res_next.gpio_write = 1'b1;
                    res_next.done       = 1'b1;
                    res_next.read_byte  = (op_reg == OP_XCVR_RD) ? incoming_reg : 8'h00;
                end
                else
                begin
                    res_next.gpio_write = 1'b1;
                    res_next.busy       = 1'b1;
                    step_next           = step_reg + 7'd1;
                    if (op_reg != OP_XCVR_RD || step_reg < RD_PHASE_BASE)
                        res_next.gpio_value = send_word(step_reg[5:1], step_reg[0], bytes_reg,
                                                        shadow_reg, cfg.clock_mask,
                                                        cfg.dout_mask);
                    else if (step_reg == RD_DESELECT)
                        res_next.gpio_value = shadow_reg | held_reg;
                    else if (step_reg == RD_RESELECT)
                        res_next.gpio_value = shadow_reg & ~held_reg;
                    else if (step_reg < RD_BITS_START)
                        res_next.gpio_value = send_word(step_reg[5:1] - 5'd1, step_reg[0],
                                                        bytes_reg, shadow_reg,
                                                        cfg.clock_mask, cfg.dout_mask);
                    else if (!step_reg[0])
                        res_next.gpio_value = shadow_reg & ~cfg.clock_mask;
                    else
                    begin
                        // sample on the clock-rising word
                        incoming_next       = {incoming_reg[6:0], e.level};
                        res_next.gpio_value = shadow_reg | cfg.clock_mask;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= '0;
            op_reg       <= OP_CODEC_WR;
            busy_reg     <= 1'b0;
            shadow_reg   <= '0;
            held_reg     <= '0;
            bytes_reg    <= '0;
            incoming_reg <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            step_reg     <= step_next;
            op_reg       <= op_next;
            busy_reg     <= busy_next;
            shadow_reg   <= shadow_next;
            held_reg     <= held_next;
            bytes_reg    <= bytes_next;
            incoming_reg <= incoming_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

// ===== hw/rtl/gscm_checker.sv =====
// Port-level checker for the serial codec control master, bound to the top level.
`include "gpio_serial_codec_control_master_top_assert.svh"

module gscm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic       result_stall,
    input logic [7:0] gpio_value,
    input logic       gpio_write,
    input logic       busy_res,
    input logic       done_res,
    input logic [7:0] read_byte,
    input logic       rejected
);

    `GSCM_ASSERT(a_idle_word_zero, result_valid && !gpio_write |-> gpio_value == 8'h00, "gpio_value set without gpio_write")
    `GSCM_ASSERT(a_done_shape, result_valid && done_res |-> gpio_write && !busy_res && !rejected, "done transaction malformed")
    `GSCM_ASSERT(a_read_byte_only_done, result_valid && !done_res |-> read_byte == 8'h00, "read_byte set outside done")
    `GSCM_ASSERT(a_stall_hold, result_valid && result_stall |=> result_valid && $stable(gpio_value), "stalled result changed")
    `GSCM_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !result_valid, "result valid right after reset")

endmodule

bind gpio_serial_codec_control_master_top gscm_checker u_gscm_checker (.*);
